// ----- src/alt_pkg.sv -----
package alt_pkg;

    localparam int unsigned LEN_W     = 8;
    localparam int unsigned TOK_LEN_W = 6;
    localparam int unsigned COL_W     = 16;
    localparam int unsigned QDEPTH    = 4;
    localparam int unsigned QPTR_W    = 2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_DQUOT = 8'h22;
    localparam logic [7:0] CH_SQUOT = 8'h27;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam logic [COL_W-1:0] COL_MAX = '1;

    typedef enum logic [1:0] {
        MODE_PLAIN  = 2'd0,
        MODE_STRING = 2'd1,
        MODE_CHAR   = 2'd2
    } t_mode;

    // one queued work unit: an optional token byte, then an optional end marker
    typedef struct packed {
        logic             has_byte;
        logic             has_end;
        logic [7:0]       data;
        logic [COL_W-1:0] start;
        logic [LEN_W-1:0] len;
    } t_entry;

endpackage

// ----- src/alt_front.sv -----
module alt_front #(
    parameter int unsigned MAX_LEN = 64
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_beat,
    input  logic [7:0]      i_ch,
    output logic            o_push,
    output alt_pkg::t_entry o_entry
);

    localparam int unsigned CW = $clog2(MAX_LEN);
    localparam logic [CW:0] LIMIT = (CW + 1)'(MAX_LEN - 1);

    alt_pkg::t_mode              r_mode, n_mode;
    logic                        r_inside, n_inside;
    logic                        r_comment, n_comment;
    logic [alt_pkg::COL_W-1:0]   r_col, n_col;
    logic [alt_pkg::COL_W-1:0]   r_start, n_start;
    logic [CW-1:0]               r_count, n_count;
    logic                        r_pb, n_pb;

    logic                        is_sep;
    logic                        is_semi;
    alt_pkg::t_mode              cur_mode;
    logic [alt_pkg::COL_W-1:0]   cur_start;
    logic [CW-1:0]               cur_count;
    logic                        cur_pb;
    logic [CW:0]                 cnt1;
    logic                        close_q;
    alt_pkg::t_entry             ent;

    assign is_sep  = (i_ch == alt_pkg::CH_SPACE) || (i_ch == alt_pkg::CH_COMMA)
                  || (i_ch == alt_pkg::CH_TAB);
    assign is_semi = (i_ch == alt_pkg::CH_SEMI);

    // a byte that opens a token sees fresh token state
    assign cur_mode  = r_inside ? r_mode  : alt_pkg::MODE_PLAIN;
    assign cur_start = r_inside ? r_start : r_col;
    assign cur_count = r_inside ? r_count : '0;
    assign cur_pb    = r_inside && r_pb;
    assign cnt1      = {1'b0, cur_count} + (CW + 1)'(1);

    always_comb begin
        n_mode    = r_mode;
        n_inside  = r_inside;
        n_comment = r_comment;
        n_col     = r_col;
        n_start   = r_start;
        n_count   = r_count;
        n_pb      = r_pb;
        close_q   = 1'b0;
        ent       = '0;
        ent.start = cur_start;
        if (i_ch == alt_pkg::CH_NUL) begin
            ent.has_end = r_inside;
            ent.start   = r_start;
            ent.len     = alt_pkg::LEN_W'(r_count);
            n_mode      = alt_pkg::MODE_PLAIN;
            n_inside    = 1'b0;
            n_comment   = 1'b0;
            n_col       = '0;
            n_start     = '0;
            n_count     = '0;
            n_pb        = 1'b0;
        end else begin
            if (r_col != alt_pkg::COL_MAX) begin
                n_col = r_col + alt_pkg::COL_W'(1);
            end
            if (r_comment) begin
                n_comment = 1'b1;
            end else if (!r_inside && is_sep) begin
                n_inside = 1'b0;
            end else if (!r_inside && is_semi) begin
                n_comment = 1'b1;
            end else if (cur_mode == alt_pkg::MODE_PLAIN && (is_sep || is_semi)) begin
                ent.has_end = 1'b1;
                ent.len     = alt_pkg::LEN_W'(cur_count);
                n_inside    = 1'b0;
                n_count     = '0;
                n_pb        = 1'b0;
                n_comment   = is_semi;
            end else begin
                n_mode = cur_mode;
                if (cur_mode == alt_pkg::MODE_PLAIN) begin
                    if (i_ch == alt_pkg::CH_DQUOT) begin
                        n_mode = alt_pkg::MODE_STRING;
                    end else if (i_ch == alt_pkg::CH_SQUOT) begin
                        n_mode = alt_pkg::MODE_CHAR;
                    end
                end else if (cur_mode == alt_pkg::MODE_STRING) begin
                    close_q = (i_ch == alt_pkg::CH_DQUOT) && !cur_pb;
                end else begin
                    close_q = (i_ch == alt_pkg::CH_SQUOT) && !cur_pb;
                end
                ent.has_byte = 1'b1;
                ent.data     = i_ch;
                ent.len      = alt_pkg::LEN_W'(cnt1);
                n_inside     = 1'b1;
                n_start      = cur_start;
                n_count      = cnt1[CW-1:0];
                n_pb         = (i_ch == alt_pkg::CH_BSL);
                if (close_q || cnt1 >= LIMIT) begin
                    ent.has_end = 1'b1;
                    n_inside    = 1'b0;
                    n_mode      = alt_pkg::MODE_PLAIN;
                    n_count     = '0;
                    n_pb        = 1'b0;
                end
            end
        end
    end

    assign o_push  = i_beat && (ent.has_byte || ent.has_end);
    assign o_entry = ent;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= alt_pkg::MODE_PLAIN;
            r_inside  <= 1'b0;
            r_comment <= 1'b0;
            r_col     <= '0;
            r_start   <= '0;
            r_count   <= '0;
            r_pb      <= 1'b0;
        end else if (i_beat) begin
            r_mode    <= n_mode;
            r_inside  <= n_inside;
            r_comment <= n_comment;
            r_col     <= n_col;
            r_start   <= n_start;
            r_count   <= n_count;
            r_pb      <= n_pb;
        end
    end

endmodule

// ----- src/alt_queue.sv -----
module alt_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  alt_pkg::t_entry i_entry,
    input  logic            i_pop,
    output alt_pkg::t_entry o_head,
    output logic            o_full,
    output logic            o_empty
);

    alt_pkg::t_entry                r_mem [alt_pkg::QDEPTH];
    logic [alt_pkg::QPTR_W-1:0]     r_wr;
    logic [alt_pkg::QPTR_W-1:0]     r_rd;
    logic [alt_pkg::QPTR_W:0]       r_cnt;

    assign o_head  = r_mem[r_rd];
    assign o_full  = (r_cnt == (alt_pkg::QPTR_W + 1)'(alt_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + alt_pkg::QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + alt_pkg::QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (alt_pkg::QPTR_W + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - (alt_pkg::QPTR_W + 1)'(1);
            end
        end
    end

endmodule

// ----- src/alt_back.sv -----
module alt_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  alt_pkg::t_entry                 i_head,
    input  logic                            i_empty,
    input  logic                            i_ready,
    output logic                            o_pop,
    output logic                            o_valid,
    output logic                            o_is_end,
    output logic [7:0]                      o_out_byte,
    output logic [alt_pkg::COL_W-1:0]       o_start_column,
    output logic [alt_pkg::TOK_LEN_W-1:0]   o_token_length
);

    // set once the byte beat of the head entry has gone and its end marker remains
    logic r_phase;
    logic byte_beat;
    logic beat;

    assign byte_beat      = i_head.has_byte && !r_phase;
    assign beat           = o_valid && i_ready;
    assign o_valid        = !i_empty;
    assign o_is_end       = !byte_beat;
    assign o_out_byte     = byte_beat ? i_head.data : 8'h00;
    assign o_start_column = i_head.start;
    assign o_token_length = i_head.len[alt_pkg::TOK_LEN_W-1:0];
    assign o_pop          = beat && !(byte_beat && i_head.has_end);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 1'b0;
        end else if (beat) begin
            r_phase <= !o_pop;
        end
    end

endmodule

// ----- src/asm_line_tokenizer_core.sv -----
// channel | direction | handshake          | payload
// input   | in        | i_valid / o_ready  | i_ch
// output  | out       | o_valid / i_ready  | o_is_end, o_out_byte, o_start_column,
//         |           |                    | o_token_length
//
// one source byte per cycle, while the queue has room, is classified and queued;
// a byte yielding a token byte plus an end marker is sent as a byte beat, then an
// end beat, from a four-entry queue drained one beat per cycle unless stalled.
// reset is synchronous and active low; it clears the line state and the queue.
// input stalls only while the queue is full; the output side stalls on its own.
module asm_line_tokenizer_core #(
    parameter int unsigned MAX_LEN = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_ch,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic                            o_is_end,
    output logic [7:0]                      o_out_byte,
    output logic [alt_pkg::COL_W-1:0]       o_start_column,
    output logic [alt_pkg::TOK_LEN_W-1:0]   o_token_length
);

    logic            in_beat;
    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    alt_pkg::t_entry entry;
    alt_pkg::t_entry head;

    assign o_ready = !full;
    assign in_beat = i_valid && o_ready;

    alt_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (in_beat),
        .i_ch    (i_ch),
        .o_push  (push),
        .o_entry (entry)
    );

    alt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full),
        .o_empty (empty)
    );

    alt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_empty        (empty),
        .i_ready        (i_ready),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .o_is_end       (o_is_end),
        .o_out_byte     (o_out_byte),
        .o_start_column (o_start_column),
        .o_token_length (o_token_length)
    );

endmodule
